[hdl/fmfs_pkg.sv]
package fmfs_pkg;

    // Map geometry.
    localparam int MAP_UNITS = 4096;
    localparam int ADDR_W    = $clog2(MAP_UNITS);
    localparam int CNT_W     = ADDR_W + 1;

    // Item operation codes.
    typedef enum logic {
        OP_MARK   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    // Search rules.
    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_USE_START = 1'b0,
        CFG_USE_SIZE  = 1'b1
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DECIDE,
        S_RESULT
    } state_t;

    // One request.
    typedef struct packed {
        op_t                op;
        fit_t               strategy;
        logic [CNT_W-1:0]   req_size;
        logic [ADDR_W-1:0]  entry_addr;
        logic               entry_used;
    } req_t;

    // One result.
    typedef struct packed {
        logic               found;
        logic [ADDR_W-1:0]  alloc_addr;
    } result_t;

    // Control from the sequencer to the run unit.
    typedef struct packed {
        logic               clear;
        logic               step;
        logic [ADDR_W-1:0]  bit_addr;
        logic               last;
        logic               runs_mode;
        logic               best;
        logic [CNT_W-1:0]   size;
    } scan_ctrl_t;

    // Status from the run unit back to the sequencer.
    typedef struct packed {
        logic               hit;
        logic [ADDR_W-1:0]  hit_addr;
        logic               runs_found;
        logic [ADDR_W-1:0]  runs_addr;
    } scan_stat_t;

endpackage

[hdl/fmfs_map_ram.sv]
module fmfs_map_ram
    import fmfs_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data
);

    logic map_mem [MAP_UNITS];
    logic rd_data_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/fmfs_run_unit.sv]
module fmfs_run_unit
    import fmfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_ctrl_t ctrl,
    input  logic       bit_used,
    output scan_stat_t stat
);

    logic [CNT_W-1:0]  run_len_reg, run_len_next;
    logic [ADDR_W-1:0] run_first_reg, run_first_next;
    logic              have_reg, have_next;
    logic [CNT_W-1:0]  pick_len_reg, pick_len_next;
    logic [ADDR_W-1:0] pick_addr_reg, pick_addr_next;

    logic              unit_free;
    logic [CNT_W-1:0]  ext_len;
    logic [CNT_W-1:0]  cand_len;
    logic [ADDR_W-1:0] cand_first;
    logic              run_close;
    logic              take;

    // Length and start of the free run if the current unit extends it.
    always_comb
    begin
        unit_free  = !bit_used;
        ext_len    = run_len_reg + CNT_W'(1);
        cand_first = (run_len_reg == '0) ? ctrl.bit_addr : run_first_reg;
        cand_len   = unit_free ? ext_len : run_len_reg;
        run_close  = ctrl.step && (bit_used || ctrl.last);
    end

    // Candidate selection for best and worst fit when a run closes.
    always_comb
    begin
        take = 1'b0;
        if (run_close && ctrl.runs_mode && (cand_len != '0))
        begin
            if (ctrl.best)
            begin
                take = (cand_len >= ctrl.size) && (!have_reg || (cand_len < pick_len_reg));
            end
            else
            begin
                take = !have_reg || (cand_len > pick_len_reg);
            end
        end
    end

    // Next values of the run and pick registers.
    always_comb
    begin
        run_len_next   = run_len_reg;
        run_first_next = run_first_reg;
        have_next      = have_reg;
        pick_len_next  = pick_len_reg;
        pick_addr_next = pick_addr_reg;
        if (ctrl.clear)
        begin
            run_len_next = '0;
            have_next    = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (unit_free)
            begin
                run_len_next   = ext_len;
                run_first_next = cand_first;
            end
            else
            begin
                run_len_next = '0;
            end
            if (take)
            begin
                have_next      = 1'b1;
                pick_len_next  = cand_len;
                pick_addr_next = cand_first;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= '0;
            have_reg    <= 1'b0;
        end
        else
        begin
            run_len_reg <= run_len_next;
            have_reg    <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_first_reg <= run_first_next;
        pick_len_reg  <= pick_len_next;
        pick_addr_reg <= pick_addr_next;
    end

    // A first-fit or next-fit scan stops once the run reaches the requested size.
    always_comb
    begin
        stat.hit        = ctrl.step && !ctrl.runs_mode && unit_free && (ext_len == ctrl.size);
        stat.hit_addr   = cand_first;
        stat.runs_found = have_reg && (pick_len_reg >= ctrl.size);
        stat.runs_addr  = pick_addr_reg;
    end

endmodule

[hdl/free_map_fit_search.sv]
// Free-run allocator search over a 4096-unit used/free map. After reset the block runs a
// clearing pass with busy high; configuration writes are taken at any time (cfg_ready is
// always high) but must only be issued while the block is idle. A request is taken when
// start is high and busy is low. For a mark request the map bit is written as the request
// is taken and the result follows in the next cycle. A next-fit search makes a second
// pass from the window start when it wraps; the map is read one unit per cycle through a
// single memory read port, and one shared run counter and comparator judges each unit.
// The result appears for exactly one cycle with done high and cannot be stalled. A search
// never marks units as used.
module free_map_fit_search
    import fmfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_index_t        cfg_index,
    input  logic [CNT_W-1:0]  cfg_data
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] use_start_reg;
    logic [CNT_W-1:0]  use_size_reg;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    fit_t              strategy_reg, strategy_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] scan_addr_reg, scan_addr_next;
    logic [ADDR_W-1:0] scan_hi_reg, scan_hi_next;
    logic              issue_reg, issue_next;
    logic              phase_reg, phase_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_last_reg, pend_last_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    result_t           result_reg, result_next;

    logic [CNT_W:0]    win_sum;
    logic [CNT_W-1:0]  win_end;
    logic              win_ok;
    logic [ADDR_W-1:0] win_top;
    logic [ADDR_W-1:0] cur_eff;
    logic [CNT_W:0]    cur_plus;
    logic [ADDR_W-1:0] wrap_hi;
    logic              search_ok;
    logic              runs_mode;
    logic              accept;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic              mem_wr_data;
    logic              mem_rd_en;
    logic              mem_rd_data;
    scan_ctrl_t        ctrl;
    scan_stat_t        stat;

    assign accept    = start && !busy;
    assign runs_mode = (strategy_reg == FIT_BEST) || (strategy_reg == FIT_WORST);

    // Heap window, clamped to the map, and the next-fit starting point.
    always_comb
    begin
        win_sum   = {2'b00, use_start_reg} + {1'b0, use_size_reg};
        win_end   = (win_sum > (CNT_W+1)'(MAP_UNITS)) ? CNT_W'(MAP_UNITS) : win_sum[CNT_W-1:0];
        win_ok    = {1'b0, use_start_reg} < win_end;
        win_top   = ADDR_W'(win_end - CNT_W'(1));
        cur_eff   = (cursor_reg < use_start_reg) ? use_start_reg : cursor_reg;
        cur_plus  = {2'b00, cur_eff} + {1'b0, size_reg};
        wrap_hi   = (cur_plus < {2'b00, win_top}) ? cur_plus[ADDR_W-1:0] : win_top;
        search_ok = (size_reg != '0) && win_ok;
    end

    // Map write port: clearing pass or a mark request.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = req.entry_addr;
        mem_wr_data = req.entry_used;
        if (state_reg == S_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = 1'b0;
        end
        else if (accept && (req.op == OP_MARK))
        begin
            mem_wr_en = 1'b1;
        end
    end

    assign mem_rd_en = (state_reg == S_SCAN) && issue_reg;

    fmfs_map_ram u_map_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (mem_rd_data)
    );

    // Control for the shared run unit.
    always_comb
    begin
        ctrl.clear     = (state_reg == S_SETUP)
                      || ((state_reg == S_SCAN) && pend_valid_reg && pend_last_reg && !phase_reg
                          && (strategy_reg == FIT_NEXT));
        ctrl.step      = (state_reg == S_SCAN) && pend_valid_reg;
        ctrl.bit_addr  = pend_addr_reg;
        ctrl.last      = pend_last_reg;
        ctrl.runs_mode = runs_mode;
        ctrl.best      = (strategy_reg == FIT_BEST);
        ctrl.size      = size_reg;
    end

    fmfs_run_unit u_run_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .bit_used (mem_rd_data),
        .stat     (stat)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(MAP_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (req.op == OP_MARK) ? S_RESULT : S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = search_ok ? S_SCAN : S_RESULT;
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = S_RESULT;
                end
                else if (pend_valid_reg && pend_last_reg)
                begin
                    if (runs_mode)
                    begin
                        state_next = S_DECIDE;
                    end
                    else if ((strategy_reg == FIT_NEXT) && !phase_reg)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_DECIDE:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer datapath.
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        cursor_next     = cursor_reg;
        strategy_next   = strategy_reg;
        size_next       = size_reg;
        scan_addr_next  = scan_addr_reg;
        scan_hi_next    = scan_hi_reg;
        issue_next      = 1'b0;
        phase_next      = phase_reg;
        pend_valid_next = 1'b0;
        pend_last_next  = pend_last_reg;
        pend_addr_next  = pend_addr_reg;
        result_next     = result_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    strategy_next = req.strategy;
                    size_next     = req.req_size;
                    result_next   = '0;
                end
            end
            S_SETUP:
            begin
                result_next    = '0;
                scan_addr_next = use_start_reg;
                scan_hi_next   = win_top;
                phase_next     = 1'b0;
                issue_next     = search_ok;
                if (strategy_reg == FIT_NEXT)
                begin
                    if (cur_eff <= win_top)
                    begin
                        scan_addr_next = cur_eff;
                    end
                    else
                    begin
                        scan_hi_next = wrap_hi;
                        phase_next   = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one map read per cycle up to the inclusive upper bound.
                issue_next      = issue_reg && (scan_addr_reg != scan_hi_reg);
                pend_valid_next = issue_reg;
                pend_last_next  = (scan_addr_reg == scan_hi_reg);
                pend_addr_next  = scan_addr_reg;
                if (issue_reg)
                begin
                    scan_addr_next = scan_addr_reg + ADDR_W'(1);
                end
                if (stat.hit)
                begin
                    issue_next           = 1'b0;
                    pend_valid_next      = 1'b0;
                    result_next.found    = 1'b1;
                    result_next.alloc_addr = stat.hit_addr;
                    // The cursor moves past the run, clamped to the top of the window.
                    if (strategy_reg == FIT_NEXT)
                    begin
                        cursor_next = (pend_addr_reg == win_top) ? pend_addr_reg
                                                                 : pend_addr_reg + ADDR_W'(1);
                    end
                end
                else if (pend_valid_reg && pend_last_reg && (strategy_reg == FIT_NEXT)
                         && !phase_reg)
                begin
                    // Wrap to the window start for the second next-fit pass.
                    scan_addr_next = use_start_reg;
                    scan_hi_next   = wrap_hi;
                    phase_next     = 1'b1;
                    issue_next     = 1'b1;
                end
            end
            S_DECIDE:
            begin
                result_next.found      = stat.runs_found;
                result_next.alloc_addr = stat.runs_found ? stat.runs_addr : '0;
            end
            S_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            cursor_reg     <= '0;
            use_start_reg  <= '0;
            use_size_reg   <= CNT_W'(MAP_UNITS);
            issue_reg      <= 1'b0;
            phase_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cursor_reg     <= cursor_next;
            issue_reg      <= issue_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_USE_START: use_start_reg <= cfg_data[ADDR_W-1:0];
                    CFG_USE_SIZE:  use_size_reg  <= cfg_data;
                    default:       use_size_reg  <= use_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        strategy_reg  <= strategy_next;
        size_reg      <= size_next;
        scan_addr_reg <= scan_addr_next;
        scan_hi_reg   <= scan_hi_next;
        pend_last_reg <= pend_last_next;
        pend_addr_reg <= pend_addr_next;
        result_reg    <= result_next;
    end

    // Port outputs.
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_RESULT);
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fmfs_pkg::*;

    localparam int REQ_W = $bits(req_t);

    // Kinds of entries in the stimulus plan.
    typedef enum {
        STEP_REQ,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t        kind;
        req_t              r;
        bit                no_idle;
        cfg_index_t        idx;
        logic [CNT_W-1:0]  data;
    } plan_step_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    req_t              req = '0;
    logic              done;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_index_t        cfg_index = CFG_USE_START;
    logic [CNT_W-1:0]  cfg_data = '0;

    // Stimulus plan, expected allocations and handshake bookkeeping.
    plan_step_t plan_q[$];
    result_t    alloc_expect_q[$];
    logic       req_taken = 1'b0;
    logic       cfg_taken = 1'b0;
    int         gap_left = 0;
    int         quiet_cycles = 0;
    int         error_count = 0;
    bit         phase_no_idle = 1'b0;

    // Shadow copy of the allocator state.
    bit         unit_used [MAP_UNITS];
    int         fit_cursor = 0;
    int         win_start = 0;
    int         win_size = MAP_UNITS;

    free_map_fit_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Lowest run of size free units lying wholly in [lo, hi].
    function automatic bit find_first_run(int lo, int hi, int size, output int at);
        int run;
        run = 0;
        at = 0;
        for (int i = lo; i <= hi; i++)
        begin
            if (unit_used[i])
            begin
                run = 0;
            end
            else
            begin
                run++;
                if (run == size)
                begin
                    at = i + 1 - run;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Best fit picks the smallest fitting run, worst fit the largest run.
    function automatic bit pick_run(int lo, int hi_end, int size, bit best, output int at);
        bit have;
        int pick;
        int pick_len;
        int i;
        int first;
        int len;
        have = 1'b0;
        pick = 0;
        pick_len = 0;
        at = 0;
        i = lo;
        while (i < hi_end)
        begin
            if (unit_used[i])
            begin
                i++;
            end
            else
            begin
                first = i;
                while (i < hi_end && !unit_used[i])
                    i++;
                len = i - first;
                if (best)
                begin
                    if (len >= size && (!have || len < pick_len))
                    begin
                        have = 1'b1;
                        pick = first;
                        pick_len = len;
                    end
                end
                else if (!have || len > pick_len)
                begin
                    have = 1'b1;
                    pick = first;
                    pick_len = len;
                end
            end
        end
        if (!have || pick_len < size)
            return 1'b0;
        at = pick;
        return 1'b1;
    endfunction

    // Applies one request to the shadow state and returns the allocation it yields.
    function automatic result_t predict_alloc(req_t r);
        result_t res;
        bit      hit;
        int      at;
        int      win_end;
        int      top;
        int      size;
        int      c;
        int      lim;
        res = '0;
        hit = 1'b0;
        at = 0;
        if (r.op == OP_MARK)
        begin
            unit_used[r.entry_addr] = r.entry_used;
        end
        else
        begin
            win_end = win_start + win_size;
            if (win_end > MAP_UNITS)
                win_end = MAP_UNITS;
            size = int'(r.req_size);
            if (size != 0 && win_start < win_end)
            begin
                top = win_end - 1;
                case (r.strategy)
                    FIT_FIRST:
                    begin
                        hit = find_first_run(win_start, top, size, at);
                    end
                    FIT_NEXT:
                    begin
                        c = (fit_cursor < win_start) ? win_start : fit_cursor;
                        if (c <= top)
                            hit = find_first_run(c, top, size, at);
                        // Wrap around: rescan from the window start past the cursor.
                        if (!hit)
                        begin
                            lim = (c + size < top) ? c + size : top;
                            hit = find_first_run(win_start, lim, size, at);
                        end
                        if (hit)
                            fit_cursor = (at + size < top) ? at + size : top;
                    end
                    default:
                    begin
                        hit = pick_run(win_start, win_end, size, r.strategy == FIT_BEST, at);
                    end
                endcase
            end
            if (hit)
            begin
                res.found = 1'b1;
                res.alloc_addr = at[ADDR_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit no_idle);
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, 2);
        if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t mk_mark(int addr, bit used);
        req_t r;
        r = '0;
        r.op = OP_MARK;
        r.entry_addr = ADDR_W'(addr);
        r.entry_used = used;
        return r;
    endfunction

    function automatic req_t mk_search(fit_t rule, int size);
        req_t r;
        r = '0;
        r.op = OP_SEARCH;
        r.strategy = rule;
        r.req_size = CNT_W'(size);
        return r;
    endfunction

    task automatic add_req(req_t r);
        plan_step_t s;
        s.kind = STEP_REQ;
        s.r = r;
        s.no_idle = phase_no_idle;
        s.idx = CFG_USE_START;
        s.data = '0;
        plan_q.push_back(s);
    endtask

    task automatic add_cfg(cfg_index_t idx, int value);
        plan_step_t s;
        s.kind = STEP_CFG;
        s.r = '0;
        s.no_idle = phase_no_idle;
        s.idx = idx;
        s.data = CNT_W'(value);
        plan_q.push_back(s);
    endtask

    task automatic add_drain();
        plan_step_t s;
        s.kind = STEP_DRAIN;
        s.r = '0;
        s.no_idle = 1'b0;
        s.idx = CFG_USE_START;
        s.data = '0;
        plan_q.push_back(s);
    endtask

    // The window is only changed once all outstanding results are back.
    task automatic set_window(int ws, int wz);
        add_drain();
        add_cfg(CFG_USE_START, ws);
        add_cfg(CFG_USE_SIZE, wz);
    endtask

    // Driver: issues the plan at falling edges, one handshake at a time.
    always @(negedge clk)
    begin
        plan_step_t head;
        logic       next_start;
        logic       next_cfg_valid;
        next_start = start;
        next_cfg_valid = cfg_valid;
        if (req_taken)
            next_start = 1'b0;
        if (cfg_taken)
            next_cfg_valid = 1'b0;
        if (rst_n && !next_start && !next_cfg_valid && plan_q.size() != 0)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else
            begin
                head = plan_q[0];
                case (head.kind)
                    STEP_REQ:
                    begin
                        req <= head.r;
                        next_start = 1'b1;
                        gap_left = pick_gap(head.no_idle);
                        plan_q.delete(0);
                    end
                    STEP_CFG:
                    begin
                        cfg_index <= head.idx;
                        cfg_data <= head.data;
                        next_cfg_valid = 1'b1;
                        gap_left = pick_gap(head.no_idle);
                        plan_q.delete(0);
                    end
                    default:
                    begin
                        // Hold off until the block is idle with nothing outstanding.
                        if (alloc_expect_q.size() == 0 && !busy)
                        begin
                            quiet_cycles++;
                            if (quiet_cycles >= 4)
                            begin
                                quiet_cycles = 0;
                                plan_q.delete(0);
                            end
                        end
                        else
                        begin
                            quiet_cycles = 0;
                        end
                    end
                endcase
            end
        end
        start <= next_start;
        cfg_valid <= next_cfg_valid;
    end

    // Monitor: checks results, predicts accepted requests, tracks register writes.
    always @(posedge clk)
    begin
        result_t want;
        req_taken <= start && !busy;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (done)
            begin
                if (alloc_expect_q.size() == 0)
                begin
                    flag_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = alloc_expect_q.pop_front();
                    if (result.found !== want.found)
                        flag_mismatch($sformatf("found %b, expected %b",
                                                result.found, want.found));
                    if (result.alloc_addr !== want.alloc_addr)
                        flag_mismatch($sformatf("alloc_addr %0d, expected %0d",
                                                result.alloc_addr, want.alloc_addr));
                end
            end
            if (start && !busy)
                alloc_expect_q.push_back(predict_alloc(req));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_USE_START: win_start = int'(cfg_data[ADDR_W-1:0]);
                    CFG_USE_SIZE:  win_size = int'(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // Stimulus plan, reset and end of run.
    initial
    begin
        int   ph;
        int   k;
        int   ws;
        int   wz;
        int   span;
        int   n_items;
        int   pick;
        int   sel;
        int   sz;
        int   addr;
        req_t r;
        logic [REQ_W-1:0] raw;

        // Full map after reset: extremes of addresses and sizes.
        add_req(mk_mark(MAP_UNITS - 1, 1'b1));
        add_req(mk_mark(0, 1'b1));
        add_req(mk_mark(2048, 1'b1));
        add_req(mk_search(FIT_FIRST, MAP_UNITS));
        add_req(mk_search(FIT_WORST, 2047));
        add_req(mk_search(FIT_BEST, 2047));
        add_req(mk_search(FIT_NEXT, 8));
        add_req(mk_search(FIT_FIRST, 0));
        add_req(mk_mark(0, 1'b0));
        add_req(mk_mark(MAP_UNITS - 1, 1'b0));
        add_req(mk_mark(2048, 1'b0));
        add_req(mk_search(FIT_FIRST, MAP_UNITS));

        // Small fragmented window; the cursor starts below it.
        set_window(100, 20);
        add_req(mk_mark(105, 1'b1));
        add_req(mk_mark(106, 1'b1));
        add_req(mk_mark(112, 1'b1));
        add_req(mk_search(FIT_BEST, 5));
        add_req(mk_search(FIT_BEST, 6));
        add_req(mk_search(FIT_WORST, 7));
        add_req(mk_search(FIT_WORST, 8));
        add_req(mk_search(FIT_NEXT, 3));
        add_req(mk_search(FIT_NEXT, 7));
        add_req(mk_search(FIT_NEXT, 5));

        // Shrunk window leaves the cursor above the top unit.
        set_window(100, 4);
        add_req(mk_search(FIT_NEXT, 2));

        // Empty window, then a window clamped at the end of the map.
        set_window(0, 0);
        add_req(mk_search(FIT_FIRST, 1));
        set_window(MAP_UNITS - 1, 8191);
        add_req(mk_search(FIT_NEXT, 1));
        add_req(mk_search(FIT_WORST, 2));

        // Random phases, mostly small windows.
        for (ph = 0; ph < 11; ph++)
        begin
            case (ph)
                3:
                begin
                    ws = 0;
                    wz = MAP_UNITS;
                end
                5:
                begin
                    ws = $urandom_range(4064, MAP_UNITS - 1);
                    wz = 48;
                end
                8:
                begin
                    ws = $urandom_range(0, 255);
                    wz = 8191;
                end
                default:
                begin
                    ws = $urandom_range(0, MAP_UNITS - 1);
                    wz = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48);
                end
            endcase
            set_window(ws, wz);
            span = ((ws + wz > MAP_UNITS) ? MAP_UNITS : ws + wz) - ws;
            phase_no_idle = ($urandom_range(0, 3) == 0);
            n_items = (ph == 3 || ph == 8) ? 6 : 12;
            for (k = 0; k < n_items; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    add_drain();
                if (pick < 35)
                begin
                    // Marks mostly land inside the window to fragment it.
                    if (span > 0 && $urandom_range(0, 4) != 0)
                        addr = ws + $urandom_range(0, span - 1);
                    else
                        addr = $urandom_range(0, MAP_UNITS - 1);
                    r = mk_mark(addr, 1'($urandom_range(0, 1)));
                    r.strategy = fit_t'($urandom_range(0, 3));
                    r.req_size = CNT_W'($urandom_range(0, 8191));
                end
                else if (pick < 42)
                begin
                    raw = REQ_W'($urandom);
                    r = raw;
                end
                else
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 5)
                        sz = 0;
                    else if (sel < 15)
                        sz = $urandom_range(0, 8191);
                    else
                        sz = $urandom_range(1, span + 2);
                    r = mk_search(fit_t'($urandom_range(0, 3)), sz);
                    r.entry_addr = ADDR_W'($urandom_range(0, MAP_UNITS - 1));
                    r.entry_used = 1'($urandom_range(0, 1));
                end
                add_req(r);
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (plan_q.size() != 0 || start || cfg_valid)
            @(posedge clk);
        while (alloc_expect_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
